// ===== rtl/core/mlsp_pkg.sv =====
// ---------------------------------------------------------------------------
// mlsp_pkg
// types, constants and step functions of the 512-bit shadow permutation
// ---------------------------------------------------------------------------
package mlsp_pkg;

  localparam int STEP_COUNT = 6;
  localparam int STEP_W     = $clog2(STEP_COUNT + 1);
  localparam int NBUND      = 4;
  localparam int NROW       = 4;
  localparam int NRC        = 12;
  localparam int RC_W       = $clog2(NRC);
  localparam int STATE_W    = NBUND * NROW * 32;

  // bundle, row, bit: matches the stream packing of the state
  typedef logic [NBUND-1:0][NROW-1:0][31:0] state_t;

  typedef logic [NROW-1:0] rc_mask_t;

  // bit r set: row r of every bundle gets 1 << bundle
  localparam rc_mask_t RC_ROWS [NRC] = '{
    4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h6, 4'hC, 4'hB, 4'h5, 4'hA, 4'h7, 4'hE
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    logic [63:0] d;
    d = {v, v} >> n;
    return d[31:0];
  endfunction

  function automatic state_t sbox_layer(input state_t st);
    state_t o;
    logic [31:0] y0, y1, y2, y3;
    for (int b = 0; b < NBUND; b++) begin
      y1 = (st[b][0] & st[b][1]) ^ st[b][2];
      y0 = (st[b][0] & st[b][3]) ^ st[b][1];
      y3 = (y1 & st[b][3]) ^ st[b][0];
      y2 = (y0 & y1) ^ st[b][3];
      o[b][0] = y0;
      o[b][1] = y1;
      o[b][2] = y2;
      o[b][3] = y3;
    end
    return o;
  endfunction

  function automatic logic [1:0][31:0] lbox_pair(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a, b, c, d;
    logic [1:0][31:0] r;
    a = x ^ rotr(x, 12);
    b = y ^ rotr(y, 12);
    a = a ^ rotr(a, 3);
    b = b ^ rotr(b, 3);
    a = a ^ rotr(x, 17);
    b = b ^ rotr(y, 17);
    c = a ^ rotr(a, 31);
    d = b ^ rotr(b, 31);
    a = a ^ rotr(d, 26);
    b = b ^ rotr(c, 25);
    a = a ^ rotr(c, 15);
    b = b ^ rotr(d, 15);
    r[0] = a;
    r[1] = b;
    return r;
  endfunction

  function automatic state_t lbox_layer(input state_t st);
    state_t o;
    logic [1:0][31:0] p;
    for (int b = 0; b < NBUND; b++) begin
      p = lbox_pair(st[b][0], st[b][1]);
      o[b][0] = p[0];
      o[b][1] = p[1];
      p = lbox_pair(st[b][2], st[b][3]);
      o[b][2] = p[0];
      o[b][3] = p[1];
    end
    return o;
  endfunction

  function automatic state_t add_rc(input state_t st, input logic [RC_W-1:0] idx);
    state_t o;
    rc_mask_t m;
    o = st;
    m = RC_ROWS[idx];
    for (int r = 0; r < NROW; r++) begin
      for (int b = 0; b < NBUND; b++) begin
        o[b][r][b] = st[b][r][b] ^ m[r];
      end
    end
    return o;
  endfunction

  function automatic state_t dbox_layer(input state_t st);
    state_t o;
    logic [31:0] all;
    for (int r = 0; r < NROW; r++) begin
      all = st[0][r] ^ st[1][r] ^ st[2][r] ^ st[3][r];
      for (int b = 0; b < NBUND; b++) begin
        o[b][r] = st[b][r] ^ all;
      end
    end
    return o;
  endfunction

  function automatic state_t step(input state_t st, input logic [STEP_W-1:0] s);
    state_t t;
    logic [RC_W-1:0] i0;
    i0 = RC_W'({s, 1'b0});
    t = sbox_layer(st);
    t = lbox_layer(t);
    t = add_rc(t, i0);
    t = sbox_layer(t);
    t = dbox_layer(t);
    t = add_rc(t, i0 | RC_W'(1));
    return t;
  endfunction

endpackage

// ===== rtl/core/mlsp_round.sv =====
// ---------------------------------------------------------------------------
// mlsp_round
// one registered permutation step with valid/ready flow control
// ---------------------------------------------------------------------------
module mlsp_round (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mlsp_pkg::STEP_W-1:0]  step_idx,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mlsp_pkg::state_t             in_state,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mlsp_pkg::state_t             out_state
);

  logic             valid;
  mlsp_pkg::state_t state;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_state = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      state <= mlsp_pkg::step(in_state, step_idx);
    end
  end

endmodule

// ===== rtl/core/mls_permutation_512.sv =====
// ---------------------------------------------------------------------------
// mls_permutation_512
// 512-bit shadow permutation, one step per pipeline stage
// ---------------------------------------------------------------------------
// usage:
//   s_* carries the input state, m_* the permuted state, both as a
//   512-bit item; tdata holds bundle 0 rows 0..3 in the lowest 128 bits,
//   then bundles 1, 2 and 3, each row a 32-bit word
//   an item is taken at each edge with tvalid and tready both high
//   one register per step; throughput is one item per cycle while
//   m_tready is high; each of the six stages is one full step
//   (s-box, l-box, constant, s-box, d-box, constant)
//   reset clears all stage valid bits; the pipeline comes up empty and
//   ready
//   when m_tready is low the stages fill up and hold; s_tready drops
//   only once every stage holds an item, and nothing is lost or repeated
// ---------------------------------------------------------------------------
module mls_permutation_512 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // b0_rows01, b0_rows23, b1_rows01, b1_rows23, b2_rows01, b2_rows23,
  // b3_rows01, b3_rows23
  input  logic [mlsp_pkg::STATE_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // o0_rows01, o0_rows23, o1_rows01, o1_rows23, o2_rows01, o2_rows23,
  // o3_rows01, o3_rows23
  output logic [mlsp_pkg::STATE_W-1:0]   m_tdata
);

  logic             valid [mlsp_pkg::STEP_COUNT+1];
  logic             ready [mlsp_pkg::STEP_COUNT+1];
  mlsp_pkg::state_t state [mlsp_pkg::STEP_COUNT+1];

  assign valid[0] = s_tvalid;
  assign s_tready = ready[0];
  assign state[0] = mlsp_pkg::state_t'(s_tdata);

  for (genvar i = 0; i < mlsp_pkg::STEP_COUNT; i++) begin : g_step
    mlsp_round u_round (
      .clk       (clk),
      .rst       (rst),
      .step_idx  (mlsp_pkg::STEP_W'(i)),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_state  (state[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_state (state[i+1])
    );
  end

  assign ready[mlsp_pkg::STEP_COUNT] = m_tready;
  assign m_tvalid = valid[mlsp_pkg::STEP_COUNT];
  assign m_tdata  = mlsp_pkg::STATE_W'(state[mlsp_pkg::STEP_COUNT]);

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ready_pass : assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  a_empty_tail : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with free last stage");

endmodule
